// ===== rtl/etf_pkg.sv =====
// shared constants for the escape-time fractal pixel block
// register indexes, default widths and reset values in q4.28
// no dependencies
package etf_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int ITER_BITS_DEF  = 16;
	localparam int INDEX_BITS_DEF = 12;

	localparam int CFG_INDEX_BITS = 3;
	localparam int GRAY_BITS      = 8;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t REG_VIEW_X_ORIGIN = 3'd0;
	localparam cfg_index_t REG_VIEW_X_STEP   = 3'd1;
	localparam cfg_index_t REG_VIEW_Y_ORIGIN = 3'd2;
	localparam cfg_index_t REG_VIEW_Y_STEP   = 3'd3;
	localparam cfg_index_t REG_ITER_LIMIT    = 3'd4;
	localparam cfg_index_t REG_JULIA_SELECT  = 3'd5;
	localparam cfg_index_t REG_JULIA_C_REAL  = 3'd6;
	localparam cfg_index_t REG_JULIA_C_IMAG  = 3'd7;

	// reset values given for 32-bit coordinates
	localparam logic signed [63:0] RST_VIEW_X_ORIGIN = -64'sd536870912;
	localparam logic signed [63:0] RST_VIEW_X_STEP   = 64'sd786432;
	localparam logic signed [63:0] RST_VIEW_Y_ORIGIN = -64'sd402653184;
	localparam logic signed [63:0] RST_VIEW_Y_STEP   = 64'sd786432;
	localparam logic signed [63:0] RST_JULIA_C_REAL  = -64'sd214748365;
	localparam logic signed [63:0] RST_JULIA_C_IMAG  = 64'sd174483046;
	localparam int RST_ITER_LIMIT = 256;

	// move a 32-bit coordinate constant to another coordinate width
	function automatic logic signed [63:0] q_rescale(input logic signed [63:0] v,
			input int bits);
		logic signed [63:0] r;
		if (bits <= 32) begin
			r = v >>> (32 - bits);
		end else begin
			r = v <<< (bits - 32);
		end
		return r;
	endfunction

endpackage

// ===== rtl/escape_time_fractal_pixel_top.sv =====
// escape-time fractal pixel evaluator, mandelbrot or julia, one pixel per item, uses etf_pkg
// steps: mapping in MAPX, MAPY and MAPZ; each iteration runs SQX, SQY, XY and UPD; the gray
//   divide runs in PREP and DIV, and DONE loads the output register
// throughput: one item at a time on one shared signed multiplier (three products and an
//   update step per iteration); input ready again in the cycle after the result is loaded
// reset: arst_n asynchronous, active low; clears control state, loads the default configuration
module escape_time_fractal_pixel_top #(
	parameter int COORD_BITS = etf_pkg::COORD_BITS_DEF,
	parameter int ITER_BITS  = etf_pkg::ITER_BITS_DEF,
	parameter int INDEX_BITS = etf_pkg::INDEX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// input item: column_index, row_index
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((2*INDEX_BITS+7)/8)*8-1:0]     s_tdata,
	// result item: iteration_count, gray_level
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((ITER_BITS+etf_pkg::GRAY_BITS+7)/8)*8-1:0] m_tdata,
	// result flag: inside_set
	output logic [0:0]                            m_tuser,
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  etf_pkg::cfg_index_t                   cfg_index,
	input  logic [((COORD_BITS > ITER_BITS) ? COORD_BITS : ITER_BITS)-1:0] cfg_data
);
	import etf_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int IW    = ITER_BITS;
	localparam int XW    = INDEX_BITS;
	localparam int FRAC  = CB - 4;
	// multiplier operand width: coordinates, or an index with a zero sign bit
	localparam int MW    = (CB > XW) ? CB : XW + 1;
	localparam int PW    = 2 * MW;
	localparam int DW    = IW + GRAY_BITS;
	localparam int OUT_W = ((IW + GRAY_BITS + 7) / 8) * 8;

	localparam logic signed [CB-1:0] RST_XO = CB'(q_rescale(RST_VIEW_X_ORIGIN, CB));
	localparam logic signed [CB-1:0] RST_XS = CB'(q_rescale(RST_VIEW_X_STEP, CB));
	localparam logic signed [CB-1:0] RST_YO = CB'(q_rescale(RST_VIEW_Y_ORIGIN, CB));
	localparam logic signed [CB-1:0] RST_YS = CB'(q_rescale(RST_VIEW_Y_STEP, CB));
	localparam logic signed [CB-1:0] RST_JR = CB'(q_rescale(RST_JULIA_C_REAL, CB));
	localparam logic signed [CB-1:0] RST_JI = CB'(q_rescale(RST_JULIA_C_IMAG, CB));
	localparam logic [IW-1:0] RST_LIM =
		(RST_ITER_LIMIT < (64'd1 << IW)) ? IW'(RST_ITER_LIMIT) : {IW{1'b1}};

	localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
	// |z|^2 > 4.0, with both squares carrying 2*FRAC fraction bits
	localparam logic signed [PW:0] ESC_BOUND = (PW+1)'(1) <<< (2 * FRAC + 2);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MAPX = 4'd1;
	localparam logic [3:0] ST_MAPY = 4'd2;
	localparam logic [3:0] ST_MAPZ = 4'd3;
	localparam logic [3:0] ST_SQX  = 4'd4;
	localparam logic [3:0] ST_SQY  = 4'd5;
	localparam logic [3:0] ST_XY   = 4'd6;
	localparam logic [3:0] ST_UPD  = 4'd7;
	localparam logic [3:0] ST_PREP = 4'd8;
	localparam logic [3:0] ST_DIV  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	// configuration registers
	logic signed [CB-1:0] x_origin_q, x_step_q, y_origin_q, y_step_q;
	logic signed [CB-1:0] jc_real_q, jc_imag_q;
	logic [IW-1:0]        limit_q;
	logic                 julia_q;

	// sequencer and datapath
	logic [3:0]           state_q;
	logic [XW-1:0]        col_q, row_q;
	logic signed [CB-1:0] zx_q, zy_q, cx_q, cy_q;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q, sqx_q, diff_q;
	logic [IW-1:0]        count_q;
	logic                 fresh_q;

	// gray level divider
	logic [DW-1:0]        rem_q, dv_q;
	logic [GRAY_BITS-1:0] quo_q;
	logic [2:0]           div_cnt_q;

	// output register
	logic [IW-1:0]        out_count_q;
	logic [GRAY_BITS-1:0] out_gray_q;
	logic                 out_inside_q;
	logic                 out_valid_q;

	logic signed [PW:0]   map_sum, esc_sum, nx_sum, ny_sum;
	logic signed [CB-1:0] map_sat;
	logic                 map_fits, nx_fits, ny_fits, escaped;
	logic [IW:0]          count_inc;
	logic                 count_last;
	logic                 out_load;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = OUT_W'({out_gray_q, out_count_q});
	assign m_tuser   = out_inside_q;

	// configuration writes, ignored codes cannot occur with a 3-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= RST_XO;
			x_step_q   <= RST_XS;
			y_origin_q <= RST_YO;
			y_step_q   <= RST_YS;
			limit_q    <= RST_LIM;
			julia_q    <= 1'b0;
			jc_real_q  <= RST_JR;
			jc_imag_q  <= RST_JI;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VIEW_X_ORIGIN: x_origin_q <= cfg_data[CB-1:0];
				REG_VIEW_X_STEP:   x_step_q   <= cfg_data[CB-1:0];
				REG_VIEW_Y_ORIGIN: y_origin_q <= cfg_data[CB-1:0];
				REG_VIEW_Y_STEP:   y_step_q   <= cfg_data[CB-1:0];
				REG_ITER_LIMIT:    limit_q    <= cfg_data[IW-1:0];
				REG_JULIA_SELECT:  julia_q    <= cfg_data[0];
				REG_JULIA_C_REAL:  jc_real_q  <= cfg_data[CB-1:0];
				REG_JULIA_C_IMAG:  jc_imag_q  <= cfg_data[CB-1:0];
			endcase
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			ST_MAPX: begin
				mul_a = signed'(MW'(col_q));
				mul_b = MW'(x_step_q);
			end
			ST_MAPY: begin
				mul_a = signed'(MW'(row_q));
				mul_b = MW'(y_step_q);
			end
			ST_SQX: begin
				mul_a = MW'(zx_q);
				mul_b = MW'(zx_q);
			end
			ST_SQY: begin
				mul_a = MW'(zy_q);
				mul_b = MW'(zy_q);
			end
			default: begin
				mul_a = MW'(zx_q);
				mul_b = MW'(zy_q);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
	end

	// pixel mapping: origin plus index times step, saturated
	always_comb begin
		map_sum  = (PW+1)'((state_q == ST_MAPY) ? x_origin_q : y_origin_q) + (PW+1)'(prod_q);
		map_fits = (map_sum[PW:CB-1] == {(PW-CB+2){map_sum[CB-1]}});
		if (map_fits) begin
			map_sat = map_sum[CB-1:0];
		end else if (map_sum[PW]) begin
			map_sat = COORD_MIN;
		end else begin
			map_sat = COORD_MAX;
		end
	end

	// escape test on the fresh iterate, and the next iterate with floor rounding
	assign esc_sum   = (PW+1)'(sqx_q) + (PW+1)'(prod_q);
	assign escaped   = (esc_sum > ESC_BOUND);
	assign nx_sum    = (PW+1)'(diff_q >>> FRAC) + (PW+1)'(cx_q);
	assign ny_sum    = (PW+1)'(prod_q >>> (FRAC - 1)) + (PW+1)'(cy_q);
	assign nx_fits   = (nx_sum[PW:CB-1] == {(PW-CB+2){nx_sum[CB-1]}});
	assign ny_fits   = (ny_sum[PW:CB-1] == {(PW-CB+2){ny_sum[CB-1]}});
	assign count_inc = (IW+1)'(count_q) + (IW+1)'(1);
	assign count_last = (count_inc == (IW+1)'(limit_q));
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			fresh_q   <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MAPX;
					end
				end
				ST_MAPX: state_q <= ST_MAPY;
				ST_MAPY: state_q <= ST_MAPZ;
				ST_MAPZ: begin
					count_q <= '0;
					fresh_q <= 1'b0;
					// a zero limit runs no iteration at all
					state_q <= (limit_q == '0) ? ST_PREP : ST_SQX;
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_XY;
				ST_XY: begin
					if (fresh_q && escaped) begin
						state_q <= ST_PREP;
					end else if (fresh_q) begin
						count_q <= count_inc[IW-1:0];
						state_q <= count_last ? ST_PREP : ST_UPD;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					fresh_q <= 1'b1;
					// an iterate leaving the coordinate range has escaped
					state_q <= (nx_fits && ny_fits) ? ST_SQX : ST_PREP;
				end
				ST_PREP: begin
					div_cnt_q <= 3'd7;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == 3'd0) begin
						state_q <= ST_DONE;
					end else begin
						div_cnt_q <= div_cnt_q - 3'd1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			col_q <= s_tdata[XW-1:0];
			row_q <= s_tdata[2*XW-1:XW];
		end
		if (state_q == ST_MAPY) begin
			zx_q <= map_sat;
		end
		if (state_q == ST_MAPZ) begin
			zy_q <= map_sat;
			cx_q <= julia_q ? jc_real_q : zx_q;
			cy_q <= julia_q ? jc_imag_q : map_sat;
		end
		if (state_q == ST_SQY) begin
			sqx_q <= prod_q;
		end
		if (state_q == ST_XY) begin
			diff_q <= sqx_q - prod_q;
		end
		if (state_q == ST_UPD && nx_fits && ny_fits) begin
			zx_q <= nx_sum[CB-1:0];
			zy_q <= ny_sum[CB-1:0];
		end
		// gray = floor(255*count/limit), quotient known to fit in 8 bits
		if (state_q == ST_PREP) begin
			rem_q <= (DW'(count_q) << GRAY_BITS) - DW'(count_q);
			dv_q  <= DW'(limit_q) << (GRAY_BITS - 1);
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (rem_q >= dv_q) begin
				rem_q <= rem_q - dv_q;
				quo_q <= {quo_q[GRAY_BITS-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[GRAY_BITS-2:0], 1'b0};
			end
			dv_q <= dv_q >> 1;
		end
		if (out_load) begin
			out_count_q  <= count_q;
			out_gray_q   <= (limit_q == '0) ? '0 : quo_q;
			out_inside_q <= (count_q == limit_q);
		end
	end

	// output register, holds a finished item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_accept_starts_map: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_MAPX)
		else $error("accepted item did not start mapping");

	a_update_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |=> state_q == ST_SQX || state_q == ST_PREP)
		else $error("bad state after iterate update");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && div_cnt_q == 3'd0 |=> state_q == ST_DONE)
		else $error("divider did not finish after eight steps");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result item shown without a finished computation");
`endif

endmodule

// ===== bench/escape_time_fractal_pixel_top_tb.sv =====
// self-checking bench for the escape-time fractal pixel block, mandelbrot and julia modes
// predicts every pixel result in q4.28 with its own register copy and checks the result stream
// depends on etf_pkg and escape_time_fractal_pixel_top
`timescale 1ns / 1ps

module escape_time_fractal_pixel_top_tb;
	import etf_pkg::*;

	localparam int COORD_W = COORD_BITS_DEF;
	localparam int ITER_W  = ITER_BITS_DEF;
	localparam int INDEX_W = INDEX_BITS_DEF;
	localparam int FRAC_W  = COORD_W - 4;
	localparam int S_W     = ((2*INDEX_W+7)/8)*8;
	localparam int M_W     = ((ITER_W+GRAY_BITS+7)/8)*8;
	localparam int CFG_W   = (COORD_W > ITER_W) ? COORD_W : ITER_W;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	// |z|^2 > 4.0 with 56 fraction bits in the squared sum
	localparam longint unsigned ESCAPE_BOUND = 64'h0400_0000_0000_0000;
	localparam logic [31:0] Q_ONE = 32'h1000_0000;

	localparam int unsigned TIMEOUT_CYCLES = 8_000_000;
	localparam int RX_HOLD_CYCLES = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 100;
	localparam int MAX_REPORTS    = 60;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 52;

	typedef struct {
		logic [ITER_W-1:0]    iter_count;
		logic [GRAY_BITS-1:0] gray;
		logic                 inside_set;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_W-1:0] s_tdata;   // column_index, row_index
	logic m_tvalid;
	logic m_tready;
	logic [M_W-1:0] m_tdata;   // iteration_count, gray_level
	logic [0:0] m_tuser;       // inside_set
	logic cfg_valid;
	logic cfg_ready;
	cfg_index_t cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// register copy used by the predictor, starts at the reset view
	longint view_x0 = RST_VIEW_X_ORIGIN;
	longint view_xs = RST_VIEW_X_STEP;
	longint view_y0 = RST_VIEW_Y_ORIGIN;
	longint view_ys = RST_VIEW_Y_STEP;
	int unsigned iter_limit = RST_ITER_LIMIT;
	bit julia_mode = 1'b0;
	longint julia_re = RST_JULIA_C_REAL;
	longint julia_im = RST_JULIA_C_IMAG;

	pixel_result_t expected_pixels[$];
	int mismatch_count = 0;
	int unsigned cycle_count = 0;

	// idling controls shared between the test tasks and the result sink
	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;
	bit hold_request = 1'b0;
	bit hold_active = 1'b0;

	escape_time_fractal_pixel_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog, sized for one pixel at the top limit plus the random phases
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("FAIL escape_time_fractal_pixel_top");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	function automatic longint clamp_q428(input longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	function automatic bit fits_q428(input longint v);
		return (v >= Q_MIN) && (v <= Q_MAX);
	endfunction

	function automatic longint unsigned mag_sq(input longint v);
		longint unsigned a;
		a = (v < 0) ? longint'(-v) : longint'(v);
		return a * a;
	endfunction

	// maps the pixel to a point and runs z = z*z + c until escape or the limit
	function automatic pixel_result_t escape_time_of(input logic [INDEX_W-1:0] col,
			input logic [INDEX_W-1:0] row);
		longint zr, zi, cr, ci, nr, ni;
		int unsigned count;
		pixel_result_t r;
		zr = clamp_q428(view_x0 + longint'(col) * view_xs);
		zi = clamp_q428(view_y0 + longint'(row) * view_ys);
		cr = julia_mode ? julia_re : zr;
		ci = julia_mode ? julia_im : zi;
		count = 0;
		while (count < iter_limit) begin
			// products are floored back to q4.28, 2*zr*zi folds the doubling into the shift
			nr = (longint'(mag_sq(zr) - mag_sq(zi)) >>> FRAC_W) + cr;
			ni = ((zr * zi) >>> (FRAC_W - 1)) + ci;
			// a part leaving q4.28 has magnitude 8 or more, so it has escaped
			if (!fits_q428(nr) || !fits_q428(ni))
				break;
			zr = nr;
			zi = ni;
			// exactly 4.0 still counts as bounded
			if (mag_sq(zr) + mag_sq(zi) > ESCAPE_BOUND)
				break;
			count++;
		end
		r.iter_count = count[ITER_W-1:0];
		r.gray = (iter_limit == 0) ? '0 : GRAY_BITS'((64'd255 * count) / iter_limit);
		r.inside_set = (count == iter_limit);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	task automatic note_mismatch(input string field, input longint want, input longint got);
		if (mismatch_count < MAX_REPORTS)
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
		mismatch_count++;
	endtask

	// compares every accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		pixel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$error("result item with no pixel outstanding: tdata %h tuser %b",
						m_tdata, m_tuser);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata[ITER_W-1:0] !== want.iter_count)
					note_mismatch("iteration_count", want.iter_count, m_tdata[ITER_W-1:0]);
				if (m_tdata[ITER_W +: GRAY_BITS] !== want.gray)
					note_mismatch("gray_level", want.gray, m_tdata[ITER_W +: GRAY_BITS]);
				if (m_tuser[0] !== want.inside_set)
					note_mismatch("inside_set", want.inside_set, m_tuser[0]);
			end
		end
	end

	// ---------------------------------------------------------------
	// idling and the result sink
	// ---------------------------------------------------------------

	// mostly back to back, some short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 24);
		return $urandom_range(40, 300);
	endfunction

	// ready toggles at random; on request it holds off for a long counted stretch
	initial begin : result_sink
		int on_len, gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				hold_active = 1'b1;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end
			m_tready <= 1'b1;
			on_len = rx_gaps_on ? $urandom_range(1, 16) : 64;
			repeat (on_len) @(posedge clk);
			gap = rx_gaps_on ? idle_gap() : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// offers one pixel item; tvalid stays high afterwards so the next item
	// can follow with no idle gap, drain_results lowers it
	task automatic send_pixel(input logic [INDEX_W-1:0] col, input logic [INDEX_W-1:0] row);
		int gap;
		gap = tx_gaps_on ? idle_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_W'({row, col});
		do @(posedge clk); while (!s_tready);
		expected_pixels.push_back(escape_time_of(col, row));
	endtask

	task automatic send_random_pixel();
		send_pixel(INDEX_W'($urandom), INDEX_W'($urandom));
	endtask

	// sender stops and waits until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write; valid stays high for a following write, cfg_release ends a batch
	task automatic reg_write(input cfg_index_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_VIEW_X_ORIGIN: view_x0 = longint'($signed(val));
			REG_VIEW_X_STEP:   view_xs = longint'($signed(val));
			REG_VIEW_Y_ORIGIN: view_y0 = longint'($signed(val));
			REG_VIEW_Y_STEP:   view_ys = longint'($signed(val));
			REG_ITER_LIMIT:    iter_limit = val[ITER_W-1:0];
			REG_JULIA_SELECT:  julia_mode = val[0];
			REG_JULIA_C_REAL:  julia_re = longint'($signed(val));
			REG_JULIA_C_IMAG:  julia_im = longint'($signed(val));
			default: ;
		endcase
	endtask

	task automatic cfg_release();
		cfg_valid <= 1'b0;
	endtask

	// flat view: every pixel maps to the same point
	task automatic write_point(input logic [31:0] re, input logic [31:0] im);
		reg_write(REG_VIEW_X_ORIGIN, re);
		reg_write(REG_VIEW_X_STEP, 32'd0);
		reg_write(REG_VIEW_Y_ORIGIN, im);
		reg_write(REG_VIEW_Y_STEP, 32'd0);
	endtask

	function automatic logic [31:0] rand_signed(input int unsigned span);
		return 32'($urandom_range(0, 2*span)) - 32'(span);
	endfunction

	// small limits keep the run short, a few phases at the default depth
	function automatic logic [31:0] pick_limit();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return $urandom_range(1, 8);
		if (r < 7) return $urandom_range(9, 64);
		if (r < 9) return $urandom_range(65, 200);
		return RST_ITER_LIMIT;
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset view and limit, three corners of the index range and two inner pixels
	task automatic test_reset_view();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'hFFF, 12'd0);
		send_pixel(12'hAAA, 12'h555);
		send_pixel(12'h555, 12'hAAA);
		drain_results();
	endtask

	// zero limit, limit of one, and the largest limit both inside and escaping
	task automatic test_limit_extremes();
		reg_write(REG_ITER_LIMIT, 32'd0);
		cfg_release();
		send_pixel(12'd100, 12'd100);
		drain_results();
		reg_write(REG_ITER_LIMIT, 32'd1);
		cfg_release();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd683, 12'd512);
		drain_results();
		// origin stays at zero forever: the full 65535 iterations run
		write_point(32'd0, 32'd0);
		reg_write(REG_ITER_LIMIT, 32'd65535);
		cfg_release();
		send_pixel(12'hFFF, 12'hFFF);
		drain_results();
		write_point(Q_ONE, 32'd0);
		cfg_release();
		send_pixel(12'd7, 12'd7);
		drain_results();
	endtask

	// mapped point saturation at both ends, and an iterate leaving q4.28
	task automatic test_saturation();
		reg_write(REG_ITER_LIMIT, 32'd16);
		reg_write(REG_JULIA_SELECT, 32'd0);
		reg_write(REG_VIEW_X_ORIGIN, 32'h7FFF_FFFF);
		reg_write(REG_VIEW_X_STEP, 32'h7FFF_FFFF);
		reg_write(REG_VIEW_Y_ORIGIN, 32'd0);
		reg_write(REG_VIEW_Y_STEP, 32'd0);
		cfg_release();
		send_pixel(12'hFFF, 12'd0);
		send_pixel(12'd0, 12'd3);
		drain_results();
		reg_write(REG_VIEW_X_ORIGIN, 32'h8000_0000);
		reg_write(REG_VIEW_X_STEP, 32'h8000_0000);
		cfg_release();
		send_pixel(12'hFFF, 12'hFFF);
		drain_results();
		reg_write(REG_VIEW_X_ORIGIN, 32'd0);
		reg_write(REG_VIEW_X_STEP, 32'd0);
		reg_write(REG_VIEW_Y_ORIGIN, 32'h8000_0000);
		reg_write(REG_VIEW_Y_STEP, 32'h8000_0000);
		cfg_release();
		send_pixel(12'd0, 12'hFFF);
		drain_results();
		// z = 3.0 squares to 9.0, outside q4.28
		write_point(32'h3000_0000, 32'd0);
		cfg_release();
		send_pixel(12'd5, 12'd5);
		drain_results();
	endtask

	// |z|^2 landing exactly on 4.0 and one lsb past it
	task automatic test_escape_boundary();
		reg_write(REG_ITER_LIMIT, 32'd50);
		write_point(32'd0, 32'd0);
		reg_write(REG_JULIA_SELECT, 32'd1);
		reg_write(REG_JULIA_C_REAL, 32'h2000_0000);
		reg_write(REG_JULIA_C_IMAG, 32'd0);
		cfg_release();
		send_pixel(12'd1, 12'd2);
		drain_results();
		reg_write(REG_JULIA_C_REAL, 32'h2000_0001);
		cfg_release();
		send_pixel(12'd1, 12'd2);
		drain_results();
		// c = -2 sits on the fixed point z = 2 and never escapes
		reg_write(REG_JULIA_SELECT, 32'd0);
		reg_write(REG_VIEW_X_ORIGIN, 32'hE000_0000);
		cfg_release();
		send_pixel(12'd9, 12'd9);
		drain_results();
		reg_write(REG_VIEW_X_ORIGIN, 32'hDFFF_FFFF);
		cfg_release();
		send_pixel(12'd9, 12'd9);
		drain_results();
		write_point(32'd0, 32'h2000_0000);
		cfg_release();
		send_pixel(12'd0, 12'd0);
		drain_results();
	endtask

	// julia mode over a normal view, then the constant at its extremes
	task automatic test_julia();
		reg_write(REG_VIEW_X_ORIGIN, 32'hE666_6666);
		reg_write(REG_VIEW_X_STEP, 32'd786432);
		reg_write(REG_VIEW_Y_ORIGIN, 32'hECCC_CCCD);
		reg_write(REG_VIEW_Y_STEP, 32'd786432);
		reg_write(REG_ITER_LIMIT, 32'd64);
		reg_write(REG_JULIA_SELECT, 32'd1);
		reg_write(REG_JULIA_C_REAL, 32'(RST_JULIA_C_REAL));
		reg_write(REG_JULIA_C_IMAG, 32'(RST_JULIA_C_IMAG));
		cfg_release();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'd1024, 12'd800);
		send_pixel(12'd2000, 12'd2000);
		send_pixel(12'd3000, 12'd1500);
		drain_results();
		reg_write(REG_JULIA_C_REAL, 32'h7FFF_FFFF);
		reg_write(REG_JULIA_C_IMAG, 32'h8000_0000);
		cfg_release();
		send_pixel(12'd1100, 12'd1100);
		drain_results();
	endtask

	// receiver holds off while the sender keeps offering, so the block stalls its input
	task automatic test_backpressure();
		reg_write(REG_JULIA_SELECT, 32'd0);
		reg_write(REG_ITER_LIMIT, 32'd3);
		cfg_release();
		tx_gaps_on = 1'b0;
		hold_request = 1'b1;
		while (!hold_active) @(posedge clk);
		repeat (12) send_random_pixel();
		tx_gaps_on = 1'b1;
		drain_results();
	endtask

	// random views and modes, registers only touched once the block is empty
	task automatic test_random_views();
		bit wild;
		int unsigned step_span;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			wild = ($urandom_range(0, 5) == 0);
			step_span = $urandom_range(0, 1) ? 300000 : 4000;
			// wild phases use full-range view words and mostly saturate
			if ($urandom_range(0, 3) != 0)
				reg_write(REG_VIEW_X_ORIGIN, wild ? $urandom : rand_signed(32'h2000_0000));
			if ($urandom_range(0, 3) != 0)
				reg_write(REG_VIEW_X_STEP, wild ? $urandom : rand_signed(step_span));
			if ($urandom_range(0, 3) != 0)
				reg_write(REG_VIEW_Y_ORIGIN, wild ? $urandom : rand_signed(32'h2000_0000));
			if ($urandom_range(0, 3) != 0)
				reg_write(REG_VIEW_Y_STEP, wild ? $urandom : rand_signed(step_span));
			reg_write(REG_ITER_LIMIT, pick_limit());
			reg_write(REG_JULIA_SELECT, 32'($urandom_range(0, 1)));
			if ($urandom_range(0, 1) != 0)
				reg_write(REG_JULIA_C_REAL, rand_signed(32'h2000_0000));
			if ($urandom_range(0, 1) != 0)
				reg_write(REG_JULIA_C_IMAG, rand_signed(32'h2000_0000));
			cfg_release();
			// some phases run with no idling on one side or both
			tx_gaps_on = ($urandom_range(0, 4) != 0);
			rx_gaps_on = ($urandom_range(0, 4) != 0);
			repeat (PHASE_ITEMS) send_random_pixel();
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_VIEW_X_ORIGIN;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_view();
		test_limit_extremes();
		test_saturation();
		test_escape_boundary();
		test_julia();
		test_backpressure();
		test_random_views();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0) begin
			$display("PASS escape_time_fractal_pixel_top");
		end else begin
			$display("FAIL escape_time_fractal_pixel_top");
		end
		$finish;
	end

endmodule
